// ----- rtl/sfr_pkg.sv -----
package sfr_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned ReplaceMax = 8;

  typedef logic [7:0]      byte_t;
  typedef logic [7:0][7:0] bytes_t;
  typedef logic [3:0]      len_t;
  typedef logic [2:0]      cfg_idx_t;
  typedef logic [63:0]     cfg_data_t;

  localparam len_t PatternMaxLen = len_t'(PatternMax);
  localparam len_t ReplaceMaxLen = len_t'(ReplaceMax);

  // register indexes of the configuration port
  localparam cfg_idx_t CfgPatternBytes     = 3'd0;
  localparam cfg_idx_t CfgPatternLen       = 3'd1;
  localparam cfg_idx_t CfgReplacementBytes = 3'd2;
  localparam cfg_idx_t CfgReplacementLen   = 3'd3;

  // effective configuration seen by the datapath
  typedef struct packed {
    bytes_t pattern;
    len_t   plen;
    bytes_t repl;
    len_t   rlen;
  } cfg_t;

  // bytes produced by one text transaction; count of zero means none
  typedef struct packed {
    bytes_t data;
    len_t   count;
    logic   text_end;
  } emit_t;

  function automatic len_t eff_len(input len_t raw, input len_t maxv);
    len_t res;
    if (raw == 4'd0) begin
      res = 4'd1;
    end else if (raw > maxv) begin
      res = maxv;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// ----- rtl/sfr_if.sv -----
interface sfr_text_if;
  logic           valid;
  logic           ready;
  sfr_pkg::byte_t text_byte;
  logic           text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface sfr_res_if;
  logic           valid;
  logic           ready;
  sfr_pkg::byte_t out_byte;
  logic           run_last;
  logic           out_end;

  modport source (output valid, output out_byte, output run_last, output out_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input out_end,
                output ready);
endinterface

interface sfr_cfg_if;
  logic                valid;
  logic                ready;
  sfr_pkg::cfg_idx_t   index;
  sfr_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/streaming_find_replace_core.sv -----
// Streaming find-and-replace: text bytes enter on text_i and the rewritten text
// leaves on res_o, with every leftmost, non-overlapping occurrence of the
// pattern (1 to 8 bytes) replaced by the replacement (1 to 8 bytes); lengths of
// 0 read as 1 and lengths above 8 read as 8. A text byte with text_end flushes
// the held bytes, and its last result carries out_end. Each text transaction
// yields between 0 and 8 result bytes, and run_last marks the last of them.
// Rate: a text byte is taken every cycle while each byte gives at most one
// result and res_o is ready; a byte that gives more holds the single output
// buffer, which drains one byte per cycle while res_o is ready; the next text
// byte enters in the cycle its final result is taken. Configuration writes
// are taken every cycle and belong between texts or while the block is idle.
module streaming_find_replace_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_text_if.sink   text_i,
  sfr_res_if.source  res_o,
  sfr_cfg_if.sink    cfg_i
);

  sfr_pkg::cfg_t  cfg;
  sfr_pkg::emit_t emit;
  logic           free;
  logic           accept;

  assign text_i.ready = free;
  assign accept       = text_i.valid && free;

  sfr_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sfr_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .text_byte_i (text_i.text_byte),
    .text_end_i  (text_i.text_end),
    .emit_o      (emit)
  );

  sfr_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .emit_i (emit),
    .free_o (free),
    .res_o  (res_o)
  );

endmodule

// ----- rtl/sfr_cfg_regs.sv -----
module sfr_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  sfr_cfg_if.sink         cfg_i,
  output sfr_pkg::cfg_t   cfg_o
);

  sfr_pkg::bytes_t pattern_q;
  sfr_pkg::bytes_t repl_q;
  sfr_pkg::len_t   plen_q;
  sfr_pkg::len_t   rlen_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      repl_q    <= '0;
      plen_q    <= 4'd1;
      rlen_q    <= 4'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sfr_pkg::CfgPatternBytes:     pattern_q <= cfg_i.data;
        sfr_pkg::CfgPatternLen:       plen_q    <= cfg_i.data[3:0];
        sfr_pkg::CfgReplacementBytes: repl_q    <= cfg_i.data;
        sfr_pkg::CfgReplacementLen:   rlen_q    <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.pattern = pattern_q;
  assign cfg_o.repl    = repl_q;
  assign cfg_o.plen    = sfr_pkg::eff_len(plen_q, sfr_pkg::PatternMaxLen);
  assign cfg_o.rlen    = sfr_pkg::eff_len(rlen_q, sfr_pkg::ReplaceMaxLen);

endmodule

// ----- rtl/sfr_window.sv -----
module sfr_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfr_pkg::cfg_t   cfg_i,
  input  logic            accept_i,
  input  sfr_pkg::byte_t  text_byte_i,
  input  logic            text_end_i,
  output sfr_pkg::emit_t  emit_o
);

  sfr_pkg::bytes_t win_q, win_d;
  sfr_pkg::len_t   cnt_q, cnt_d;

  sfr_pkg::bytes_t w;
  sfr_pkg::len_t   c;
  sfr_pkg::len_t   sel;
  logic [8:0]      pref;
  logic            full;

  always_comb begin
    // append the new byte to the held bytes
    w = win_q;
    c = cnt_q;
    if (cnt_q < 4'd8) begin
      w[cnt_q[2:0]] = text_byte_i;
      c = cnt_q + 4'd1;
    end

    // pref[k]: dropping the first k bytes leaves a prefix of the pattern
    for (int k = 0; k <= 8; k++) begin
      pref[k] = (4'(k) <= c) && ((c - 4'(k)) <= cfg_i.plen);
      for (int j = 0; j < 8; j++) begin
        if ((k + j < 8) && (4'(j) < (c - 4'(k)))) begin
          if (w[3'(k + j)] != cfg_i.pattern[3'(j)]) begin
            pref[k] = 1'b0;
          end
        end
      end
    end

    full = (c == cfg_i.plen) && pref[0];

    sel = 4'd8;
    for (int k = 8; k >= 0; k--) begin
      if (pref[k]) begin
        sel = 4'(k);
      end
    end

    emit_o.text_end = text_end_i;
    win_d = w >> {sel, 3'b000};
    if (full) begin
      emit_o.data  = cfg_i.repl;
      emit_o.count = cfg_i.rlen;
      cnt_d        = 4'd0;
    end else begin
      emit_o.data = w;
      if (text_end_i) begin
        // flush everything still held
        emit_o.count = c;
        cnt_d        = 4'd0;
      end else begin
        emit_o.count = sel;
        cnt_d        = c - sel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule

// ----- rtl/sfr_out_buf.sv -----
module sfr_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sfr_pkg::emit_t  emit_i,
  output logic            free_o,
  sfr_res_if.source       res_o
);

  sfr_pkg::bytes_t data_q;
  sfr_pkg::len_t   len_q;
  logic [2:0]      idx_q;
  logic            end_q;
  logic            last_beat;
  logic            pop;

  assign last_beat = ({1'b0, idx_q} == (len_q - 4'd1));
  assign pop       = res_o.valid && res_o.ready;
  // free once the final byte of the held transaction leaves
  assign free_o    = (len_q == 4'd0) || (pop && last_beat);

  assign res_o.valid    = (len_q != 4'd0);
  assign res_o.out_byte = data_q[idx_q];
  assign res_o.run_last = last_beat;
  assign res_o.out_end  = last_beat && end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 4'd0;
      idx_q <= 3'd0;
    end else if (load_i && (emit_i.count != 4'd0)) begin
      len_q <= emit_i.count;
      idx_q <= 3'd0;
    end else if (pop) begin
      if (last_beat) begin
        len_q <= 4'd0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= emit_i.data;
      end_q  <= emit_i.text_end;
    end
  end

endmodule
